@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the spin basis operator checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted (active low).
`define SBO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked check that also runs during reset.
`define SBO_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

@@ rtl/sbo_pkg.sv @@
// ----------------------------------------------------------------------------
// sbo_pkg
// Widths, command codes, status codes and shared types of the spin operator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbo_pkg;

    localparam int SPINS_W = 64;
    localparam int SITE_W  = 7;
    localparam int CMD_W   = 4;
    localparam int COEF_W  = 9;
    localparam int STAT_W  = 2;
    localparam int FUC_W   = 8;
    localparam int SHIFT_W = 6;

    localparam int MAX_SITES_DEF = 64;

    localparam int S_TDATA_W = 88;  // 82 payload bits, padded to bytes
    localparam int M_TDATA_W = 80;  // 73 payload bits, padded to bytes

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_UP_COUNT = 2'd1;

    localparam logic [SITE_W-1:0] SITE_COUNT_RST     = 7'd64;
    localparam logic [FUC_W-1:0]  FIXED_UP_COUNT_RST = 8'hFF;  // -1: unconstrained

    // operator commands
    localparam logic [CMD_W-1:0] CMD_SZ         = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SZSZ       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_TOTAL_SZ   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RAISE      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_LOWER      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SX         = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RAISE_PAIR = 4'd6;
    localparam logic [CMD_W-1:0] CMD_HOP        = 4'd7;
    localparam logic [CMD_W-1:0] CMD_LOWER_PAIR = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SXSX       = 4'd9;
    localparam logic [CMD_W-1:0] CMD_EXCHANGE   = 4'd10;

    // result status
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_WORD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REFUSED  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_UNUSED   = 2'd3;

    // coefficients in quarters
    localparam logic signed [COEF_W-1:0] COEF_ZERO     = 9'sd0;
    localparam logic signed [COEF_W-1:0] COEF_QUARTER  = 9'sd1;
    localparam logic signed [COEF_W-1:0] COEF_MQUARTER = -9'sd1;
    localparam logic signed [COEF_W-1:0] COEF_HALF     = 9'sd2;
    localparam logic signed [COEF_W-1:0] COEF_MHALF    = -9'sd2;
    localparam logic signed [COEF_W-1:0] COEF_ONE      = 9'sd4;

    // site decode handed from the decoder to the operator logic
    typedef struct packed {
        logic                    in_i;   // site_i below the active site count
        logic                    in_j;
        logic [SPINS_W-1:0]      bit_i;  // one-hot mask of site_i, zero if out of range
        logic [SPINS_W-1:0]      bit_j;
        logic [SPINS_W-1:0]      valid;  // bits that belong to active sites
        logic [SITE_W-1:0]       n;      // active site count, clamped
    } site_info_t;

endpackage

@@ rtl/sbo_site_decode.sv @@
// ----------------------------------------------------------------------------
// sbo_site_decode
// Clamp the site count and turn site operands into word masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbo_site_decode #(
    parameter int MAX_SITES = sbo_pkg::MAX_SITES_DEF
) (
    input  logic [sbo_pkg::SITE_W-1:0] site_count,
    input  logic [sbo_pkg::SITE_W-1:0] site_i,
    input  logic [sbo_pkg::SITE_W-1:0] site_j,
    output sbo_pkg::site_info_t        info
);

    localparam logic [sbo_pkg::SITE_W-1:0] MAX_N = sbo_pkg::SITE_W'(MAX_SITES);

    logic [sbo_pkg::SITE_W-1:0] n;
    logic [sbo_pkg::SITE_W-1:0] sh_i;
    logic [sbo_pkg::SITE_W-1:0] sh_j;

    always_comb begin
        n    = (site_count > MAX_N) ? MAX_N : site_count;
        // site k sits at bit n-1-k
        sh_i = n - sbo_pkg::SITE_W'(1) - site_i;
        sh_j = n - sbo_pkg::SITE_W'(1) - site_j;

        info.n     = n;
        info.in_i  = (site_i < n);
        info.in_j  = (site_j < n);
        info.bit_i = info.in_i ? (sbo_pkg::SPINS_W'(1) << sh_i[sbo_pkg::SHIFT_W-1:0])
                               : '0;
        info.bit_j = info.in_j ? (sbo_pkg::SPINS_W'(1) << sh_j[sbo_pkg::SHIFT_W-1:0])
                               : '0;
        if (n[sbo_pkg::SITE_W-1]) begin
            info.valid = '1;
        end else begin
            info.valid = (sbo_pkg::SPINS_W'(1) << n[sbo_pkg::SHIFT_W-1:0])
                         - sbo_pkg::SPINS_W'(1);
        end
    end

endmodule

@@ rtl/sbo_op_apply.sv @@
// ----------------------------------------------------------------------------
// sbo_op_apply
// Apply one spin operator to a basis word and form coefficient and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbo_op_apply (
    input  logic [sbo_pkg::CMD_W-1:0]          command,
    input  logic [sbo_pkg::SPINS_W-1:0]        spins,
    input  logic [sbo_pkg::SITE_W-1:0]         site_i,
    input  logic [sbo_pkg::SITE_W-1:0]         site_j,
    input  sbo_pkg::site_info_t                info,
    input  logic [sbo_pkg::FUC_W-1:0]          fixed_up_count,
    output logic [sbo_pkg::SPINS_W-1:0]        new_spins,
    output logic signed [sbo_pkg::COEF_W-1:0]  coef_quarters,
    output logic [sbo_pkg::STAT_W-1:0]         status
);

    logic                         fixed;
    logic                         up_i;
    logic                         up_j;
    logic                         both;
    logic                         same;
    logic [sbo_pkg::SITE_W-1:0]   pop;
    logic [sbo_pkg::SITE_W-1:0]   ups;
    logic [sbo_pkg::COEF_W:0]     tot;
    logic [sbo_pkg::SPINS_W-1:0]  nw;
    logic signed [sbo_pkg::COEF_W-1:0] coef;

    // popcount of the word, adder tree after synthesis
    always_comb begin
        pop = '0;
        for (int b = 0; b < sbo_pkg::SPINS_W; b++) begin
            pop = pop + sbo_pkg::SITE_W'(spins[b]);
        end
    end

    always_comb begin
        fixed = ~fixed_up_count[sbo_pkg::FUC_W-1];
        up_i  = |(spins & info.bit_i);
        up_j  = |(spins & info.bit_j);
        both  = info.in_i & info.in_j;
        same  = (site_i == site_j);

        if (fixed) begin
            ups = (fixed_up_count[sbo_pkg::SITE_W-1:0] > info.n) ? info.n
                                                              : fixed_up_count[sbo_pkg::SITE_W-1:0];
        end else begin
            ups = pop;
        end
        tot = {1'b0, ups, 2'b00} - {2'b00, info.n, 1'b0};

        nw   = spins;
        coef = sbo_pkg::COEF_ZERO;
        case (command)
            sbo_pkg::CMD_SZ: begin
                if (info.in_i) coef = up_i ? sbo_pkg::COEF_HALF : sbo_pkg::COEF_MHALF;
            end
            sbo_pkg::CMD_SZSZ: begin
                if (both) coef = (up_i == up_j) ? sbo_pkg::COEF_QUARTER
                                                : sbo_pkg::COEF_MQUARTER;
            end
            sbo_pkg::CMD_TOTAL_SZ: begin
                coef = tot[sbo_pkg::COEF_W-1:0];
            end
            sbo_pkg::CMD_RAISE: begin
                if (info.in_i && !up_i) begin
                    nw   = spins | info.bit_i;
                    coef = sbo_pkg::COEF_ONE;
                end
            end
            sbo_pkg::CMD_LOWER: begin
                if (info.in_i && up_i) begin
                    nw   = spins & ~info.bit_i;
                    coef = sbo_pkg::COEF_ONE;
                end
            end
            sbo_pkg::CMD_SX: begin
                if (info.in_i) begin
                    nw   = spins ^ info.bit_i;
                    coef = sbo_pkg::COEF_HALF;
                end
            end
            sbo_pkg::CMD_RAISE_PAIR: begin
                if (!same && both && !up_i && !up_j) begin
                    nw   = spins | info.bit_i | info.bit_j;
                    coef = sbo_pkg::COEF_ONE;
                end
            end
            sbo_pkg::CMD_HOP: begin
                if (both) begin
                    if (same) begin
                        coef = up_i ? sbo_pkg::COEF_ONE : sbo_pkg::COEF_ZERO;
                    end else if (!up_i && up_j) begin
                        nw   = (spins | info.bit_i) & ~info.bit_j;
                        coef = sbo_pkg::COEF_ONE;
                    end
                end
            end
            sbo_pkg::CMD_LOWER_PAIR: begin
                if (!same && both && up_i && up_j) begin
                    nw   = spins & ~(info.bit_i | info.bit_j);
                    coef = sbo_pkg::COEF_ONE;
                end
            end
            sbo_pkg::CMD_SXSX: begin
                // equal sites give the identity whether or not they are in range
                if (same) begin
                    coef = sbo_pkg::COEF_QUARTER;
                end else if (both) begin
                    nw   = spins ^ info.bit_i ^ info.bit_j;
                    coef = sbo_pkg::COEF_QUARTER;
                end
            end
            sbo_pkg::CMD_EXCHANGE: begin
                if (!same && both && (up_i != up_j)) begin
                    nw   = spins ^ info.bit_i ^ info.bit_j;
                    coef = sbo_pkg::COEF_HALF;
                end
            end
            default: begin
                coef = sbo_pkg::COEF_ZERO;
            end
        endcase

        // refusal outranks the word check; both leave the word untouched
        if (fixed && (command inside {sbo_pkg::CMD_RAISE, sbo_pkg::CMD_LOWER,
                                      sbo_pkg::CMD_SX, sbo_pkg::CMD_RAISE_PAIR,
                                      sbo_pkg::CMD_LOWER_PAIR, sbo_pkg::CMD_SXSX})) begin
            status        = sbo_pkg::STAT_REFUSED;
            new_spins     = spins;
            coef_quarters = sbo_pkg::COEF_ZERO;
        end else if (|(spins & ~info.valid)) begin
            status        = sbo_pkg::STAT_BAD_WORD;
            new_spins     = spins;
            coef_quarters = sbo_pkg::COEF_ZERO;
        end else begin
            status        = sbo_pkg::STAT_OK;
            new_spins     = nw;
            coef_quarters = coef;
        end
    end

endmodule

@@ rtl/spin_basis_operator_unit.sv @@
// ----------------------------------------------------------------------------
// spin_basis_operator_unit
// An accepted input beat goes through the input register, then the result register, to m_.
// Throughput: 1 beat per cycle unless m_ stalls; the input register and the result register
//   form a two-deep pipeline that advances whenever the result register is empty or taken.
// Reset: synchronous, active low; clears both valid flags and loads
//   site_count = 64 and fixed_up_count = -1 (unconstrained basis).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spin_basis_operator_unit #(
    parameter int MAX_SITES = sbo_pkg::MAX_SITES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] command, [67:4] spins, [74:68] site_i, [81:75] site_j, [87:82] zero
    input  logic [sbo_pkg::S_TDATA_W-1:0]     s_tdata,

    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [63:0] new_spins, [72:64] coef_quarters, [79:73] zero
    output logic [sbo_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [sbo_pkg::STAT_W-1:0]        m_tuser,

    // configuration writes
    input  logic                              cfg_we,
    input  logic [sbo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // ---------------------------------------------------------------------
    // Configuration registers. The user must make writes only while the pipe is empty; not enforced.
    // ---------------------------------------------------------------------
    logic [sbo_pkg::SITE_W-1:0] site_count_reg;
    logic [sbo_pkg::FUC_W-1:0]  fixed_up_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            site_count_reg     <= sbo_pkg::SITE_COUNT_RST;
            fixed_up_count_reg <= sbo_pkg::FIXED_UP_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                sbo_pkg::CFG_SITE_COUNT: begin
                    site_count_reg <= cfg_wdata[sbo_pkg::SITE_W-1:0];
                end
                sbo_pkg::CFG_FIXED_UP_COUNT: begin
                    fixed_up_count_reg <= cfg_wdata;
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control. The result register advances when it is empty or
    // being taken; the input register accepts when it is empty or moving on.
    // ---------------------------------------------------------------------
    logic in_vld_reg;
    logic in_vld_next;
    logic out_vld_reg;
    logic out_vld_next;
    logic advance;
    logic accept;

    always_comb begin
        advance      = !out_vld_reg || m_tready;
        s_tready     = !in_vld_reg || advance;
        accept       = s_tvalid && s_tready;
        in_vld_next  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // ---------------------------------------------------------------------
    // Input register: unpack the beat, hold it while the result stalls.
    // ---------------------------------------------------------------------
    logic [sbo_pkg::CMD_W-1:0]   cmd_reg;
    logic [sbo_pkg::SPINS_W-1:0] spins_reg;
    logic [sbo_pkg::SITE_W-1:0]  site_i_reg;
    logic [sbo_pkg::SITE_W-1:0]  site_j_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_tdata[3:0];
            spins_reg  <= s_tdata[67:4];
            site_i_reg <= s_tdata[74:68];
            site_j_reg <= s_tdata[81:75];
        end
    end

    // ---------------------------------------------------------------------
    // Single pass: site masks, then the operator itself.
    // ---------------------------------------------------------------------
    sbo_pkg::site_info_t                info;
    logic [sbo_pkg::SPINS_W-1:0]        new_spins;
    logic signed [sbo_pkg::COEF_W-1:0]  coef_quarters;
    logic [sbo_pkg::STAT_W-1:0]         status;

    sbo_site_decode #(
        .MAX_SITES (MAX_SITES)
    ) u_decode (
        .site_count (site_count_reg),
        .site_i     (site_i_reg),
        .site_j     (site_j_reg),
        .info       (info)
    );

    sbo_op_apply u_apply (
        .command        (cmd_reg),
        .spins          (spins_reg),
        .site_i         (site_i_reg),
        .site_j         (site_j_reg),
        .info           (info),
        .fixed_up_count (fixed_up_count_reg),
        .new_spins      (new_spins),
        .coef_quarters  (coef_quarters),
        .status         (status)
    );

    // ---------------------------------------------------------------------
    // Result register: load on advance, hold otherwise.
    // ---------------------------------------------------------------------
    logic [sbo_pkg::SPINS_W-1:0]        new_spins_reg;
    logic signed [sbo_pkg::COEF_W-1:0]  coef_reg;
    logic [sbo_pkg::STAT_W-1:0]         status_reg;

    always_ff @(posedge aclk) begin
        if (advance && in_vld_reg) begin
            new_spins_reg <= new_spins;
            coef_reg      <= coef_quarters;
            status_reg    <= status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, coef_reg, new_spins_reg};
    assign m_tuser  = status_reg;

endmodule

@@ rtl/sbo_checker.sv @@
// ----------------------------------------------------------------------------
// sbo_checker
// Port-level checks of the spin basis operator unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbo_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sbo_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sbo_pkg::STAT_W-1:0]    m_tuser
);

    logic signed [sbo_pkg::COEF_W-1:0] coef;
    logic                              err_beat;
    logic                              stat_spare;

    assign coef       = m_tdata[72:64];
    assign err_beat   = m_tvalid && (m_tuser != sbo_pkg::STAT_OK);
    assign stat_spare = (m_tuser == sbo_pkg::STAT_UNUSED);

    // no result beat right after reset
    `SBO_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // a stalled result stays offered
    `SBO_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

    // an accepted beat passes the input register and reaches the output when the sink keeps up
    `SBO_ASSERT(a_latency, aclk, aresetn, (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)

    // error results carry no coefficient, and the spare status code never shows
    `SBO_ASSERT(a_err_coef, aclk, aresetn, err_beat |-> (coef == sbo_pkg::COEF_ZERO) && !stat_spare)

    // coefficient stays within plus or minus 32 in units of one
    `SBO_ASSERT(a_coef_range, aclk, aresetn, m_tvalid |-> (coef >= -9'sd128) && (coef <= 9'sd128))

endmodule

bind spin_basis_operator_unit sbo_checker u_sbo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
